// ----- hdl/ftprn_pkg.sv -----
package ftprn_pkg;

	// Default width of the saturating printed-character counter
	localparam int COUNT_BITS_DEF = 32;

	// Depth of the queue between the front and the back
	localparam int QUEUE_DEPTH = 4;

	// Characters the logic looks for or prints
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LOW_S   = 8'h73;
	localparam logic [7:0] CH_LOW_D   = 8'h64;
	localparam logic [7:0] CH_LOW_X   = 8'h78;

	// Input item kinds as carried on s_axis_tuser
	typedef enum logic [2:0] {
		CMD_FORMAT   = 3'd0,
		CMD_NUMBER   = 3'd1,
		CMD_STR_BYTE = 3'd2,
		CMD_STR_END  = 3'd3,
		CMD_NULL_STR = 3'd4,
		CMD_FINISH   = 3'd5
	} cmd_t;

	// Conversion waiting for its argument
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_STR  = 2'd1,
		PEND_DEC  = 2'd2,
		PEND_HEX  = 2'd3
	} pend_t;

	// Work handed from the front to the back
	typedef enum logic [2:0] {
		OP_CHAR   = 3'd0,
		OP_DEC    = 3'd1,
		OP_HEX    = 3'd2,
		OP_NULL   = 3'd3,
		OP_REPORT = 3'd4
	} op_t;

	typedef struct packed {
		op_t         kind;
		logic [7:0]  byte_val;
		logic [31:0] num;
	} op_req_t;

	// Result kinds as carried on m_axis_tuser
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DEC  = 2'd1,
		BK_HEX  = 2'd2,
		BK_NULL = 2'd3
	} back_st_t;

	// Lowercase digit for a nibble
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10)
			c = 8'h30 + {4'b0, d};
		else
			c = 8'h57 + {4'b0, d};
		return c;
	endfunction

	// Text printed for a null string argument
	function automatic logic [7:0] null_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h28;
			3'd1: c = 8'h6E;
			3'd2: c = 8'h75;
			3'd3: c = 8'h6C;
			3'd4: c = 8'h6C;
			3'd5: c = 8'h29;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Decimal place weights
	function automatic logic [31:0] pow10(input logic [3:0] pos);
		logic [31:0] w;
		case (pos)
			4'd0: w = 32'd1;
			4'd1: w = 32'd10;
			4'd2: w = 32'd100;
			4'd3: w = 32'd1000;
			4'd4: w = 32'd10000;
			4'd5: w = 32'd100000;
			4'd6: w = 32'd1000000;
			4'd7: w = 32'd10000000;
			4'd8: w = 32'd100000000;
			4'd9: w = 32'd1000000000;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

	// Constant table: digit j times the weight of place pos
	function automatic logic [35:0] dec_mult(input logic [3:0] pos, input logic [3:0] j);
		return 36'(j) * 36'(pow10(pos));
	endfunction

endpackage

// ----- hdl/ftprn_front.sv -----
module ftprn_front
	import ftprn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [2:0]  in_cmd,
	input  logic [7:0]  in_byte,
	input  logic [31:0] in_num,
	output logic        in_ready,
	output logic        push_valid,
	output op_req_t     push_req,
	input  logic        push_ready
);

	logic  after_q, after_d;
	pend_t pend_q, pend_d;
	logic  accept, do_push;
	op_t   push_kind;

	assign in_ready = push_ready;
	assign accept   = in_valid & push_ready;

	// Classify the request and track specifier state
	always_comb begin
		after_d   = after_q;
		pend_d    = pend_q;
		do_push   = 1'b0;
		push_kind = OP_CHAR;
		case (cmd_t'(in_cmd))
			CMD_FORMAT: begin
				pend_d = PEND_NONE;
				if (after_q) begin
					after_d = 1'b0;
					if (in_byte == CH_LOW_S)
						pend_d = PEND_STR;
					else if (in_byte == CH_LOW_D)
						pend_d = PEND_DEC;
					else if (in_byte == CH_LOW_X)
						pend_d = PEND_HEX;
				end else if (in_byte == CH_PERCENT) begin
					after_d = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end
			CMD_NUMBER: begin
				if (pend_q == PEND_DEC) begin
					do_push   = 1'b1;
					push_kind = OP_DEC;
				end else if (pend_q == PEND_HEX) begin
					do_push   = 1'b1;
					push_kind = OP_HEX;
				end
				pend_d = PEND_NONE;
			end
			CMD_STR_BYTE: begin
				do_push = (pend_q == PEND_STR);
			end
			CMD_STR_END: begin
				if (pend_q == PEND_STR)
					pend_d = PEND_NONE;
			end
			CMD_NULL_STR: begin
				if (pend_q == PEND_STR) begin
					do_push   = 1'b1;
					push_kind = OP_NULL;
					pend_d    = PEND_NONE;
				end
			end
			CMD_FINISH: begin
				do_push   = 1'b1;
				push_kind = OP_REPORT;
				after_d   = 1'b0;
				pend_d    = PEND_NONE;
			end
			default: begin
			end
		endcase
	end

	assign push_valid        = accept & do_push;
	assign push_req.kind     = push_kind;
	assign push_req.byte_val = in_byte;
	assign push_req.num      = in_num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q <= 1'b0;
			pend_q  <= PEND_NONE;
		end else if (accept) begin
			after_q <= after_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ----- hdl/ftprn_queue.sv -----
module ftprn_queue
	import ftprn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  op_req_t push_req,
	output logic    push_ready,
	output logic    pop_valid,
	output op_req_t pop_req,
	input  logic    pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	op_req_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_req    = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_req;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push & ~do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop & ~do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- hdl/ftprn_back.sv -----
module ftprn_back
	import ftprn_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  op_req_t     op_req,
	output logic        op_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  out_char,
	output logic [31:0] out_count,
	output logic        out_last
);

	back_st_t              st_q, st_d;
	logic [3:0]            pos_q, pos_d;
	logic [31:0]           mag_q, mag_d;
	logic                  started_q, started_d;
	logic [COUNT_BITS-1:0] total_q;

	logic                  out_valid_q, out_kind_q, out_last_q;
	logic [7:0]            out_char_q;
	logic [31:0]           out_count_q;

	logic                  can_emit, emit, e_kind, e_last, clr_total;
	logic [7:0]            e_char;
	logic [31:0]           e_count, rpt_count;
	logic [COUNT_BITS+31:0] total_wide;
	logic [3:0]            dec_digit, hex_digit;
	logic [35:0]           dec_sub;

	assign can_emit = ~out_valid_q | out_ready;

	// Report value saturates at 32 bits
	assign total_wide = {32'b0, total_q};
	assign rpt_count  = (|total_wide[COUNT_BITS+31:32]) ? '1 : total_wide[31:0];

	// Decimal digit at the current place: largest multiple not above the magnitude
	always_comb begin
		dec_digit = 4'd0;
		for (int j = 1; j < 10; j++) begin
			if ({4'b0, mag_q} >= dec_mult(pos_q, 4'(j)))
				dec_digit = 4'(j);
		end
		dec_sub = dec_mult(pos_q, dec_digit);
	end

	assign hex_digit = mag_q[{pos_q[2:0], 2'b00} +: 4];

	// Sequencer: turns each queued item into characters or a count report, taking the next one only from idle
	always_comb begin
		st_d      = st_q;
		pos_d     = pos_q;
		mag_d     = mag_q;
		started_d = started_q;
		op_pop    = 1'b0;
		emit      = 1'b0;
		e_kind    = KIND_CHAR;
		e_char    = 8'h00;
		e_count   = 32'h0;
		e_last    = 1'b0;
		clr_total = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (op_valid && can_emit) begin
					op_pop = 1'b1;
					case (op_req.kind)
						OP_CHAR: begin
							emit   = 1'b1;
							e_char = op_req.byte_val;
							e_last = 1'b1;
						end
						OP_REPORT: begin
							emit      = 1'b1;
							e_kind    = KIND_COUNT;
							e_count   = rpt_count;
							e_last    = 1'b1;
							clr_total = 1'b1;
						end
						OP_DEC: begin
							if (op_req.num[31]) begin
								emit   = 1'b1;
								e_char = CH_MINUS;
								mag_d  = ~op_req.num + 32'd1;
							end else begin
								mag_d  = op_req.num;
							end
							pos_d     = 4'd9;
							started_d = 1'b0;
							st_d      = BK_DEC;
						end
						OP_HEX: begin
							mag_d     = op_req.num;
							pos_d     = 4'd7;
							started_d = 1'b0;
							st_d      = BK_HEX;
						end
						OP_NULL: begin
							emit   = 1'b1;
							e_char = null_char(3'd0);
							pos_d  = 4'd1;
							st_d   = BK_NULL;
						end
						default: begin
						end
					endcase
				end
			end
			BK_DEC: begin
				if (can_emit) begin
					if (dec_digit != 4'd0 || started_q || pos_q == 4'd0) begin
						emit      = 1'b1;
						e_char    = digit_char(dec_digit);
						e_last    = (pos_q == 4'd0);
						started_d = 1'b1;
					end
					mag_d = mag_q - dec_sub[31:0];
					if (pos_q == 4'd0)
						st_d = BK_IDLE;
					else
						pos_d = pos_q - 4'd1;
				end
			end
			BK_HEX: begin
				if (can_emit) begin
					if (hex_digit != 4'd0 || started_q || pos_q == 4'd0) begin
						emit      = 1'b1;
						e_char    = digit_char(hex_digit);
						e_last    = (pos_q == 4'd0);
						started_d = 1'b1;
					end
					if (pos_q == 4'd0)
						st_d = BK_IDLE;
					else
						pos_d = pos_q - 4'd1;
				end
			end
			BK_NULL: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_char = null_char(pos_q[2:0]);
					e_last = (pos_q == 4'd5);
					if (pos_q == 4'd5)
						st_d = BK_IDLE;
					else
						pos_d = pos_q + 4'd1;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	// Sequencer registers and character total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BK_IDLE;
			pos_q     <= 4'd0;
			started_q <= 1'b0;
			total_q   <= '0;
		end else begin
			st_q      <= st_d;
			pos_q     <= pos_d;
			started_q <= started_d;
			if (clr_total)
				total_q <= '0;
			else if (emit && e_kind == KIND_CHAR && !(&total_q))
				total_q <= total_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= mag_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (can_emit)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_kind_q  <= e_kind;
			out_char_q  <= e_char;
			out_count_q <= e_count;
			out_last_q  <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_char  = out_char_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

// ----- hdl/formatted_text_printer_top.sv -----
// An accepted request's result passes through the op queue, then the output register.
// Throughput: one request per cycle while the 4-entry op queue has room; the back end
// finishes each queued item, one character at a time, before it takes the next one.
// The digit sequencer walks all ten decimal places, one per cycle unless output stalls.
// Reset (arst_n low, asynchronous): specifier state, queue, sequencer, output valid and
// the character total all clear; no clearing pass is needed.
module formatted_text_printer_top
	import ftprn_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [7:0] byte_value, [39:8] number_value
	input  logic [2:0]  s_axis_tuser,  // [2:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] out_char, [39:8] count_value
	output logic        m_axis_tuser,  // [0] result_kind
	output logic        m_axis_tlast
);

	logic    push_valid, push_ready, pop_valid, pop;
	op_req_t push_req, pop_req;
	logic [7:0]  res_char;
	logic [31:0] res_count;

	ftprn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_cmd     (s_axis_tuser),
		.in_byte    (s_axis_tdata[7:0]),
		.in_num     (s_axis_tdata[39:8]),
		.in_ready   (s_axis_tready),
		.push_valid (push_valid),
		.push_req   (push_req),
		.push_ready (push_ready)
	);

	ftprn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_req   (push_req),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_req    (pop_req),
		.pop        (pop)
	);

	ftprn_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (pop_valid),
		.op_req    (pop_req),
		.op_pop    (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_char  (res_char),
		.out_count (res_count),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {res_count, res_char};

endmodule

// ----- bench/tb_formatted_text_printer_top.sv -----
`timescale 1ns / 1ps

module tb_formatted_text_printer_top;
	import ftprn_pkg::*;

	localparam int COUNT_BITS = COUNT_BITS_DEF;
	localparam logic [63:0] COUNT_SAT = (64'd1 << COUNT_BITS) - 64'd1;
	localparam int RUN_LIMIT = 400000;
	localparam int GOOD_TARGET = 72;
	localparam int HOLD_CYCLES = 300;
	localparam string NULL_TEXT = "(null)";

	// command codes the block does not define; they must be dropped
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// one printed character or count report
	typedef struct packed {
		logic        kind;
		logic [7:0]  ch;
		logic [31:0] cnt;
		logic        last;
	} print_res_t;

	// directed request; fixed result given only where obvious
	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  b;
		logic [31:0] num;
		logic        fixed;
		logic        kind;
		logic [7:0]  ch;
		logic [31:0] cnt;
	} stim_row_t;

	localparam int N_ROWS = 28;
	localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
		'{CMD_FINISH,   8'h00,      32'h0,        1'b1, KIND_COUNT, 8'h00, 32'd0},
		'{CMD_FORMAT,   "A",        32'h0,        1'b1, KIND_CHAR,  "A",   32'd0},
		'{CMD_FORMAT,   8'h00,      32'hFFFFFFFF, 1'b1, KIND_CHAR,  8'h00, 32'd0},
		'{CMD_FORMAT,   8'hFF,      32'h0,        1'b1, KIND_CHAR,  8'hFF, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_D,   32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_NUMBER,   8'hFF,      32'h80000000, 1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_X,   32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_NUMBER,   8'h00,      32'hFFFFFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_D,   32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_NUMBER,   8'h00,      32'h0,        1'b1, KIND_CHAR,  "0",   32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_S,   32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_STR_BYTE, 8'h00,      32'h0,        1'b1, KIND_CHAR,  8'h00, 32'd0},
		'{CMD_STR_BYTE, 8'hFF,      32'h0,        1'b1, KIND_CHAR,  8'hFF, 32'd0},
		'{CMD_STR_END,  8'h00,      32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_S,   32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_NULL_STR, 8'h00,      32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_NUMBER,   8'h00,      32'h7FFFFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_LOW_D,   32'h0,        1'b1, KIND_CHAR,  CH_LOW_D, 32'd0},
		'{CMD_SPARE_7,  8'hFF,      32'hFFFFFFFF, 1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FORMAT,   CH_PERCENT, 32'h0,        1'b0, 1'b0, 8'h00, 32'd0},
		'{CMD_FINISH,   8'h00,      32'h0,        1'b0, 1'b0, 8'h00, 32'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	formatted_text_printer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// formatter state mirror
	logic        after_pct;
	pend_t       pend_conv;
	logic [63:0] chars_printed;

	print_res_t expected_prints[$];
	print_res_t step_prints[$];
	int         mismatch_count;
	int         cycle_count;
	bit         sender_burst;
	bit         hold_request;
	int         good_items;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// -------- formatter prediction --------
	function automatic void emit_char(input logic [7:0] c);
		print_res_t r;
		if (chars_printed < COUNT_SAT)
			chars_printed++;
		r = '{kind: KIND_CHAR, ch: c, cnt: 32'd0, last: 1'b0};
		step_prints.push_back(r);
	endfunction

	// digits most significant first, no leading zeros
	function automatic void emit_radix(input logic [31:0] mag, input int unsigned radix);
		logic [7:0]  digits [0:10];
		logic [31:0] d;
		int          k;
		k = 0;
		do begin
			d = mag % radix;
			// '0'..'9' then 'a'..'f'
			digits[k] = (d < 10) ? 8'h30 + d[7:0] : 8'h57 + d[7:0];
			k++;
			mag = mag / radix;
		end while (mag != 0 && k < 11);
		while (k > 0) begin
			k--;
			emit_char(digits[k]);
		end
	endfunction

	function automatic void predict_printer(input logic [2:0] cmd, input logic [7:0] b,
			input logic [31:0] num);
		print_res_t r;
		step_prints.delete();
		case (cmd)
			CMD_FORMAT: begin
				// any format byte drops a waiting conversion
				pend_conv = PEND_NONE;
				if (after_pct) begin
					after_pct = 1'b0;
					if (b == CH_LOW_S)
						pend_conv = PEND_STR;
					else if (b == CH_LOW_D)
						pend_conv = PEND_DEC;
					else if (b == CH_LOW_X)
						pend_conv = PEND_HEX;
				end else if (b == CH_PERCENT) begin
					after_pct = 1'b1;
				end else begin
					emit_char(b);
				end
			end
			CMD_NUMBER: begin
				if (pend_conv == PEND_DEC) begin
					if (num[31]) begin
						emit_char(CH_MINUS);
						emit_radix(~num + 32'd1, 10);
					end else begin
						emit_radix(num, 10);
					end
				end else if (pend_conv == PEND_HEX) begin
					emit_radix(num, 16);
				end
				pend_conv = PEND_NONE;
			end
			CMD_STR_BYTE: begin
				if (pend_conv == PEND_STR)
					emit_char(b);
			end
			CMD_STR_END: begin
				if (pend_conv == PEND_STR)
					pend_conv = PEND_NONE;
			end
			CMD_NULL_STR: begin
				if (pend_conv == PEND_STR) begin
					for (int i = 0; i < 6; i++)
						emit_char(NULL_TEXT[i]);
					pend_conv = PEND_NONE;
				end
			end
			CMD_FINISH: begin
				r.kind = KIND_COUNT;
				r.ch   = 8'h00;
				r.cnt  = (chars_printed > 64'hFFFFFFFF) ? 32'hFFFFFFFF : chars_printed[31:0];
				r.last = 1'b0;
				step_prints.push_back(r);
				after_pct     = 1'b0;
				pend_conv     = PEND_NONE;
				chars_printed = 64'd0;
			end
			default: begin
			end
		endcase
		if (step_prints.size() > 0) begin
			r = step_prints.pop_back();
			r.last = 1'b1;
			step_prints.push_back(r);
		end
	endfunction

	// -------- request side --------
	task automatic offer_item(input logic [2:0] cmd, input logic [7:0] b, input logic [31:0] num);
		int gap;
		gap = sender_burst ? 0 : idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {num, b};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_item(input logic [2:0] cmd, input logic [7:0] b, input logic [31:0] num);
		offer_item(cmd, b, num);
		predict_printer(cmd, b, num);
		foreach (step_prints[i])
			expected_prints.push_back(step_prints[i]);
	endtask

	function automatic logic [31:0] pick_number();
		logic [31:0] corners [0:8];
		logic [31:0] v;
		int r;
		corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd15, 32'd16,
			32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
		r = $urandom_range(0, 99);
		if (r < 15)
			return corners[$urandom_range(0, 8)];
		if (r < 50) begin
			v = $urandom_range(0, 999);
			return $urandom_range(0, 1) ? -v : v;
		end
		return $urandom();
	endfunction

	// plain format byte other than a percent sign
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_PERCENT)
			c = "q";
		return c;
	endfunction

	task automatic random_segment();
		int r;
		int n;
		r = $urandom_range(0, 99);
		sender_burst = ($urandom_range(0, 3) == 0);
		if (r < 28) begin
			n = $urandom_range(1, 4);
			repeat (n) send_item(CMD_FORMAT, pick_plain(), $urandom());
			good_items += n;
		end else if (r < 46) begin
			send_item(CMD_FORMAT, CH_PERCENT, $urandom());
			send_item(CMD_FORMAT, CH_LOW_D, $urandom());
			send_item(CMD_NUMBER, 8'($urandom_range(0, 255)), pick_number());
			good_items += 3;
		end else if (r < 62) begin
			send_item(CMD_FORMAT, CH_PERCENT, $urandom());
			send_item(CMD_FORMAT, CH_LOW_X, $urandom());
			send_item(CMD_NUMBER, 8'($urandom_range(0, 255)), pick_number());
			good_items += 3;
		end else if (r < 78) begin
			send_item(CMD_FORMAT, CH_PERCENT, $urandom());
			send_item(CMD_FORMAT, CH_LOW_S, $urandom());
			n = $urandom_range(0, 5);
			repeat (n) send_item(CMD_STR_BYTE, 8'($urandom_range(0, 255)), $urandom());
			if ($urandom_range(0, 4) == 0)
				send_item(CMD_NULL_STR, 8'($urandom_range(0, 255)), $urandom());
			else
				send_item(CMD_STR_END, 8'($urandom_range(0, 255)), $urandom());
			good_items += n + 3;
		end else if (r < 84) begin
			send_item(CMD_FINISH, 8'($urandom_range(0, 255)), $urandom());
			good_items++;
		end else begin
			// noise: misplaced arguments, odd specifiers, broken sequences
			case ($urandom_range(0, 5))
				0: send_item(CMD_NUMBER, 8'($urandom_range(0, 255)), $urandom());
				1: send_item(3'($urandom_range(CMD_STR_BYTE, CMD_NULL_STR)),
					8'($urandom_range(0, 255)), $urandom());
				2: send_item($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7,
					8'($urandom_range(0, 255)), $urandom());
				3: begin
					send_item(CMD_FORMAT, CH_PERCENT, $urandom());
					send_item(CMD_FORMAT, 8'($urandom_range(0, 255)), $urandom());
				end
				4: begin
					send_item(CMD_FORMAT, CH_PERCENT, $urandom());
					send_item(CMD_FORMAT, CH_LOW_D, $urandom());
					send_item(CMD_FORMAT, pick_plain(), $urandom());
				end
				default: begin
					send_item(CMD_FORMAT, CH_PERCENT, $urandom());
					send_item(CMD_FORMAT, CH_LOW_S, $urandom());
					send_item(CMD_NUMBER, 8'($urandom_range(0, 255)), pick_number());
				end
			endcase
		end
	endtask

	// -------- result side --------
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				// long hold-off so the op queue fills and input stalls
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat (($urandom_range(0, 99) < 20) ? $urandom_range(30, 80)
						: $urandom_range(1, 8)) @(posedge clk);
				m_axis_tready <= 1'b0;
				repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin : check_prints
		print_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_prints.size() == 0) begin
				note_mismatch($sformatf("unexpected result kind=%0d data=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = expected_prints.pop_front();
				if (m_axis_tuser !== want.kind)
					note_mismatch($sformatf("kind got %0d want %0d", m_axis_tuser, want.kind));
				if (m_axis_tdata[7:0] !== want.ch)
					note_mismatch($sformatf("char got %h want %h", m_axis_tdata[7:0], want.ch));
				if (m_axis_tdata[39:8] !== want.cnt)
					note_mismatch($sformatf("count got %0d want %0d",
						m_axis_tdata[39:8], want.cnt));
				if (m_axis_tlast !== want.last)
					note_mismatch($sformatf("last got %0d want %0d", m_axis_tlast, want.last));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("FAIL formatted_text_printer_top");
			$finish;
		end
	end

	// -------- main sequence --------
	initial begin
		print_res_t fixed_res;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		after_pct      = 1'b0;
		pend_conv      = PEND_NONE;
		chars_printed  = 64'd0;
		mismatch_count = 0;
		cycle_count    = 0;
		sender_burst   = 1'b0;
		hold_request   = 1'b0;
		good_items     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED_ROWS[i]) begin
			offer_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].num);
			predict_printer(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].num);
			if (DIRECTED_ROWS[i].fixed) begin
				fixed_res = '{kind: DIRECTED_ROWS[i].kind, ch: DIRECTED_ROWS[i].ch,
					cnt: DIRECTED_ROWS[i].cnt, last: 1'b1};
				expected_prints.push_back(fixed_res);
			end else begin
				foreach (step_prints[j])
					expected_prints.push_back(step_prints[j]);
			end
		end

		// random requests, with one long output hold-off early on
		hold_request = 1'b1;
		while (good_items < GOOD_TARGET)
			random_segment();
		sender_burst = 1'b0;
		send_item(CMD_FINISH, 8'($urandom_range(0, 255)), $urandom());
		s_axis_tvalid <= 1'b0;

		// drain, then keep watching for stray results
		while (expected_prints.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS formatted_text_printer_top");
		else
			$display("FAIL formatted_text_printer_top");
		$finish;
	end

endmodule
